// ----- sv/tdc_pkg.sv -----
package tdc_pkg;

   // keypad sample width
   localparam int AdcBits = 10;
   // widest configuration register is a window bound
   localparam int CsrDataBits = AdcBits;
   localparam int CsrIndexBits = 3;

   localparam int FifoDepth = 2;
   localparam int FifoPtrBits = $clog2(FifoDepth);
   localparam int FifoCountBits = $clog2(FifoDepth + 1);

   typedef logic [AdcBits-1:0] level_type;
   typedef logic [5:0] sec_type;
   typedef logic [5:0] min_type;
   typedef logic [4:0] hour_type;
   typedef logic [7:0] idle_type;
   typedef logic [FifoPtrBits-1:0] fifo_ptr_type;
   typedef logic [FifoCountBits-1:0] fifo_count_type;

   localparam sec_type SecLast = 6'd59;
   localparam min_type MinLast = 6'd59;
   localparam hour_type HourLast = 5'd23;
   localparam idle_type IdleMax = 8'd255;

   localparam level_type SetLowReset = level_type'(340);
   localparam level_type SetHighReset = level_type'(450);
   localparam level_type UpLowReset = level_type'(210);
   localparam level_type UpHighReset = level_type'(280);
   localparam level_type DownLowReset = level_type'(130);
   localparam level_type DownHighReset = level_type'(200);
   localparam idle_type IdleTimeoutReset = 8'd5;

   typedef enum logic [CsrIndexBits-1:0] {
      REG_SET_LOW      = 3'd0,
      REG_SET_HIGH     = 3'd1,
      REG_UP_LOW       = 3'd2,
      REG_UP_HIGH      = 3'd3,
      REG_DOWN_LOW     = 3'd4,
      REG_DOWN_HIGH    = 3'd5,
      REG_IDLE_TIMEOUT = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_RUN     = 2'd0,
      MODE_HOURS   = 2'd1,
      MODE_MINUTES = 2'd2
   } mode_type;

   // classified request handed from the front to the back
   typedef struct packed {
      logic tick;
      logic other;
      logic set_press;
      logic up_press;
      logic down_press;
   } item_type;

endpackage

// ----- sv/tdc_front.sv -----
module tdc_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_second_tick,
   input  logic [tdc_pkg::AdcBits-1:0]      req_key_level,
   input  logic                             req_other_screen,
   input  logic                             csr_wr_en,
   input  logic [tdc_pkg::CsrIndexBits-1:0] csr_index,
   input  logic [tdc_pkg::CsrDataBits-1:0]  csr_wdata,
   input  logic                             fifo_full,
   output logic                             push_valid,
   output tdc_pkg::item_type                push_item,
   output tdc_pkg::idle_type                idle_timeout
);

   tdc_pkg::level_type set_low_ff, set_low_in, set_high_ff, set_high_in;
   tdc_pkg::level_type up_low_ff, up_low_in, up_high_ff, up_high_in;
   tdc_pkg::level_type down_low_ff, down_low_in, down_high_ff, down_high_in;
   tdc_pkg::idle_type timeout_ff, timeout_in;
   logic set_held_ff, set_held_in, up_held_ff, up_held_in, down_held_ff, down_held_in;
   logic set_hit, up_hit, down_hit, accept;

   assign req_ready = !fifo_full;
   assign accept = req_valid && req_ready;
   assign push_valid = accept;
   assign idle_timeout = timeout_ff;

   // strict window compares
   assign set_hit = (req_key_level > set_low_ff) && (req_key_level < set_high_ff);
   assign up_hit = (req_key_level > up_low_ff) && (req_key_level < up_high_ff);
   assign down_hit = (req_key_level > down_low_ff) && (req_key_level < down_high_ff);

   always_comb begin
      push_item.tick = req_second_tick;
      push_item.other = req_other_screen;
      push_item.set_press = !req_other_screen && set_hit && !set_held_ff;
      push_item.up_press = !req_other_screen && up_hit && !up_held_ff;
      push_item.down_press = !req_other_screen && down_hit && !down_held_ff;
   end

   // held bits frozen while the other screen is shown
   always_comb begin
      set_held_in = set_held_ff;
      up_held_in = up_held_ff;
      down_held_in = down_held_ff;
      if (accept && !req_other_screen) begin
         set_held_in = set_hit;
         up_held_in = up_hit;
         down_held_in = down_hit;
      end
   end

   always_comb begin
      set_low_in = set_low_ff;
      set_high_in = set_high_ff;
      up_low_in = up_low_ff;
      up_high_in = up_high_ff;
      down_low_in = down_low_ff;
      down_high_in = down_high_ff;
      timeout_in = timeout_ff;
      if (csr_wr_en) begin
         case (csr_index)
            tdc_pkg::REG_SET_LOW:      set_low_in = csr_wdata[tdc_pkg::AdcBits-1:0];
            tdc_pkg::REG_SET_HIGH:     set_high_in = csr_wdata[tdc_pkg::AdcBits-1:0];
            tdc_pkg::REG_UP_LOW:       up_low_in = csr_wdata[tdc_pkg::AdcBits-1:0];
            tdc_pkg::REG_UP_HIGH:      up_high_in = csr_wdata[tdc_pkg::AdcBits-1:0];
            tdc_pkg::REG_DOWN_LOW:     down_low_in = csr_wdata[tdc_pkg::AdcBits-1:0];
            tdc_pkg::REG_DOWN_HIGH:    down_high_in = csr_wdata[tdc_pkg::AdcBits-1:0];
            tdc_pkg::REG_IDLE_TIMEOUT: timeout_in = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_low_ff <= tdc_pkg::SetLowReset;
         set_high_ff <= tdc_pkg::SetHighReset;
         up_low_ff <= tdc_pkg::UpLowReset;
         up_high_ff <= tdc_pkg::UpHighReset;
         down_low_ff <= tdc_pkg::DownLowReset;
         down_high_ff <= tdc_pkg::DownHighReset;
         timeout_ff <= tdc_pkg::IdleTimeoutReset;
         set_held_ff <= 1'b0;
         up_held_ff <= 1'b0;
         down_held_ff <= 1'b0;
      end else begin
         set_low_ff <= set_low_in;
         set_high_ff <= set_high_in;
         up_low_ff <= up_low_in;
         up_high_ff <= up_high_in;
         down_low_ff <= down_low_in;
         down_high_ff <= down_high_in;
         timeout_ff <= timeout_in;
         set_held_ff <= set_held_in;
         up_held_ff <= up_held_in;
         down_held_ff <= down_held_in;
      end
   end

endmodule

// ----- sv/tdc_fifo.sv -----
module tdc_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tdc_pkg::item_type push_item,
   input  logic              pop,
   output tdc_pkg::item_type pop_item,
   output logic              full,
   output logic              empty
);

   tdc_pkg::item_type entry_ff [tdc_pkg::FifoDepth];
   tdc_pkg::fifo_ptr_type wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   tdc_pkg::fifo_count_type count_ff, count_in;

   assign full = (count_ff == tdc_pkg::fifo_count_type'(tdc_pkg::FifoDepth));
   assign empty = (count_ff == '0);
   assign pop_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == tdc_pkg::fifo_ptr_type'(tdc_pkg::FifoDepth - 1)) ?
                     '0 : wr_ptr_ff + tdc_pkg::fifo_ptr_type'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == tdc_pkg::fifo_ptr_type'(tdc_pkg::FifoDepth - 1)) ?
                     '0 : rd_ptr_ff + tdc_pkg::fifo_ptr_type'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + tdc_pkg::fifo_count_type'(1);
      end else if (pop && !push) begin
         count_in = count_ff - tdc_pkg::fifo_count_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

// ----- sv/tdc_back.sv -----
module tdc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              fifo_empty,
   input  tdc_pkg::item_type pop_item,
   output logic              pop,
   input  tdc_pkg::idle_type idle_timeout,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [4:0]        rsp_hour_now,
   output logic [5:0]        rsp_minute_now,
   output logic [5:0]        rsp_second_now,
   output logic [1:0]        rsp_clock_state
);

   tdc_pkg::sec_type sec_ff, sec_in;
   tdc_pkg::min_type min_ff, min_in;
   tdc_pkg::hour_type hour_ff, hour_in;
   tdc_pkg::idle_type idle_ff, idle_in;
   tdc_pkg::mode_type mode_ff, mode_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [4:0] hour_out_ff;
   logic [5:0] min_out_ff, sec_out_ff;
   logic [1:0] state_out_ff;

   assign pop = !fifo_empty && (!rsp_valid_ff || rsp_ready);

   // one request per cycle unless the response register stalls: tick, set, timeout, up, down in that order
   always_comb begin
      sec_in = sec_ff;
      min_in = min_ff;
      hour_in = hour_ff;
      idle_in = idle_ff;
      mode_in = mode_ff;
      if (pop) begin
         if (pop_item.tick) begin
            if (mode_ff == tdc_pkg::MODE_RUN) begin
               if (sec_ff >= tdc_pkg::SecLast) begin
                  sec_in = '0;
                  if (min_ff >= tdc_pkg::MinLast) begin
                     min_in = '0;
                     hour_in = (hour_ff >= tdc_pkg::HourLast) ?
                               '0 : hour_ff + tdc_pkg::hour_type'(1);
                  end else begin
                     min_in = min_ff + tdc_pkg::min_type'(1);
                  end
               end else begin
                  sec_in = sec_ff + tdc_pkg::sec_type'(1);
               end
            end
            if (idle_ff != tdc_pkg::IdleMax) begin
               idle_in = idle_ff + tdc_pkg::idle_type'(1);
            end
         end
         if (!pop_item.other) begin
            if (pop_item.set_press) begin
               case (mode_ff)
                  tdc_pkg::MODE_RUN:   mode_in = tdc_pkg::MODE_HOURS;
                  tdc_pkg::MODE_HOURS: mode_in = tdc_pkg::MODE_MINUTES;
                  default:             mode_in = tdc_pkg::MODE_RUN;
               endcase
               idle_in = '0;
            end
            if (mode_in != tdc_pkg::MODE_RUN && idle_in > idle_timeout) begin
               mode_in = tdc_pkg::MODE_RUN;
               idle_in = '0;
            end
            if (pop_item.up_press) begin
               idle_in = '0;
               case (mode_in)
                  tdc_pkg::MODE_HOURS: begin
                     hour_in = (hour_in >= tdc_pkg::HourLast) ?
                               '0 : hour_in + tdc_pkg::hour_type'(1);
                  end
                  tdc_pkg::MODE_MINUTES: begin
                     min_in = (min_in >= tdc_pkg::MinLast) ?
                              '0 : min_in + tdc_pkg::min_type'(1);
                  end
                  default: ;
               endcase
            end
            if (pop_item.down_press) begin
               idle_in = '0;
               case (mode_in)
                  tdc_pkg::MODE_HOURS: begin
                     hour_in = (hour_in == '0) ?
                               tdc_pkg::HourLast : hour_in - tdc_pkg::hour_type'(1);
                  end
                  tdc_pkg::MODE_MINUTES: begin
                     min_in = (min_in == '0) ?
                              tdc_pkg::MinLast : min_in - tdc_pkg::min_type'(1);
                  end
                  default: ;
               endcase
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sec_ff <= '0;
         min_ff <= '0;
         hour_ff <= '0;
         idle_ff <= '0;
         mode_ff <= tdc_pkg::MODE_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         sec_ff <= sec_in;
         min_ff <= min_in;
         hour_ff <= hour_in;
         idle_ff <= idle_in;
         mode_ff <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload, loaded with the updated state
   always_ff @(posedge clock) begin
      if (pop) begin
         hour_out_ff <= hour_in;
         min_out_ff <= min_in;
         sec_out_ff <= sec_in;
         state_out_ff <= mode_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hour_now = hour_out_ff;
   assign rsp_minute_now = min_out_ff;
   assign rsp_second_now = sec_out_ff;
   assign rsp_clock_state = state_out_ff;

endmodule

// ----- sv/time_of_day_clock_with_button_setting_top.sv -----
// time-of-day clock set from a three-button resistor-ladder keypad
// request channel (req_valid / req_ready): one second-tick flag, one keypad
//   sample and an other-screen flag per request
// response channel (rsp_valid / rsp_ready): hour, minute, second and clock
//   state after that request has been applied, one response per request
// csr port: single-cycle writes of the six window bounds and the idle
//   timeout, index as listed in the package; unknown indices are dropped
// path: an accepted request is written into the queue; the back end pops it,
//   updates the time counters and loads the response register, and it pops
//   only while the response register is empty or being taken
// throughput: one request per cycle while the receiver takes the responses
// receiver stall: the response register holds, the two-entry queue takes what
//   it still has room for and req_ready falls once it is full; nothing is
//   dropped or repeated
// reset: time 00:00:00, running, held bits clear, csr registers at defaults
module time_of_day_clock_with_button_setting_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_second_tick,
   input  logic [tdc_pkg::AdcBits-1:0]      req_key_level,
   input  logic                             req_other_screen,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [4:0]                       rsp_hour_now,
   output logic [5:0]                       rsp_minute_now,
   output logic [5:0]                       rsp_second_now,
   output logic [1:0]                       rsp_clock_state,
   input  logic                             csr_wr_en,
   input  logic [tdc_pkg::CsrIndexBits-1:0] csr_index,
   input  logic [tdc_pkg::CsrDataBits-1:0]  csr_wdata
);

   // front to queue
   logic push_valid;
   tdc_pkg::item_type push_item;
   // queue to back
   tdc_pkg::item_type pop_item;
   logic pop, fifo_full, fifo_empty;
   tdc_pkg::idle_type idle_timeout;

   // front: csr registers, window compares and press-edge detection
   tdc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_second_tick  (req_second_tick),
      .req_key_level    (req_key_level),
      .req_other_screen (req_other_screen),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .fifo_full        (fifo_full),
      .push_valid       (push_valid),
      .push_item        (push_item),
      .idle_timeout     (idle_timeout)
   );

   // short queue of classified requests
   tdc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .full      (fifo_full),
      .empty     (fifo_empty)
   );

   // back: time counters, mode, idle timer and response register
   tdc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .fifo_empty      (fifo_empty),
      .pop_item        (pop_item),
      .pop             (pop),
      .idle_timeout    (idle_timeout),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_hour_now    (rsp_hour_now),
      .rsp_minute_now  (rsp_minute_now),
      .rsp_second_now  (rsp_second_now),
      .rsp_clock_state (rsp_clock_state)
   );

endmodule

// ----- bench/tb.sv -----
module tb;

   // request sides for the idle-gap generator
   localparam int SideReq = 0;
   localparam int SideRsp = 1;
   // highest keypad sample
   localparam int LevelTop = (1 << tdc_pkg::AdcBits) - 1;
   // csr index past the end of the register list, must be dropped
   localparam logic [tdc_pkg::CsrIndexBits-1:0] RegUnused = 3'd7;

   typedef logic [tdc_pkg::CsrDataBits-1:0] csr_word_type;

   typedef enum int {
      BTN_SET,
      BTN_UP,
      BTN_DOWN
   } button_type;

   // one response: time of day and clock state
   typedef struct packed {
      tdc_pkg::hour_type hour;
      tdc_pkg::min_type  minute;
      tdc_pkg::sec_type  second;
      tdc_pkg::mode_type state;
   } clock_reading_type;

   // one row of the directed table; pinned rows carry their response
   typedef struct packed {
      logic               tick;
      tdc_pkg::level_type level;
      logic               other;
      logic               pinned;
      clock_reading_type  reading;
   } stim_row_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic req_second_tick;
   tdc_pkg::level_type req_key_level;
   logic req_other_screen;
   logic rsp_valid;
   logic rsp_ready;
   logic [4:0] rsp_hour_now;
   logic [5:0] rsp_minute_now;
   logic [5:0] rsp_second_now;
   logic [1:0] rsp_clock_state;
   logic csr_wr_en;
   logic [tdc_pkg::CsrIndexBits-1:0] csr_index;
   logic [tdc_pkg::CsrDataBits-1:0] csr_wdata;

   // pinned response travelling alongside the request that is on offer
   logic pin_valid;
   clock_reading_type pin_reading;

   // predicted state of the clock
   tdc_pkg::hour_type cur_hour;
   tdc_pkg::min_type cur_minute;
   tdc_pkg::sec_type cur_second;
   tdc_pkg::mode_type cur_mode;
   tdc_pkg::idle_type idle_count;
   tdc_pkg::idle_type idle_limit;
   logic held [3];
   tdc_pkg::level_type win_low [3];
   tdc_pkg::level_type win_high [3];

   clock_reading_type expected_readings [$];
   stim_row_type directed_rows [$];
   int mismatches;

   // idle-gap generator state, one slot per side
   int calm_left [2];
   bit calm [2];

   time_of_day_clock_with_button_setting_top u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_second_tick (req_second_tick),
      .req_key_level   (req_key_level),
      .req_other_screen(req_other_screen),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_hour_now    (rsp_hour_now),
      .rsp_minute_now  (rsp_minute_now),
      .rsp_second_now  (rsp_second_now),
      .rsp_clock_state (rsp_clock_state),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------------
   // clock predictor
   // ---------------------------------------------------------------------

   function automatic void reset_clock_model();
      cur_hour = '0;
      cur_minute = '0;
      cur_second = '0;
      cur_mode = tdc_pkg::MODE_RUN;
      idle_count = '0;
      foreach (held[i]) held[i] = 1'b0;
      win_low[BTN_SET] = tdc_pkg::SetLowReset;
      win_high[BTN_SET] = tdc_pkg::SetHighReset;
      win_low[BTN_UP] = tdc_pkg::UpLowReset;
      win_high[BTN_UP] = tdc_pkg::UpHighReset;
      win_low[BTN_DOWN] = tdc_pkg::DownLowReset;
      win_high[BTN_DOWN] = tdc_pkg::DownHighReset;
      idle_limit = tdc_pkg::IdleTimeoutReset;
   endfunction

   function automatic void apply_csr(logic [tdc_pkg::CsrIndexBits-1:0] idx,
                                     logic [tdc_pkg::CsrDataBits-1:0] data);
      case (idx)
         tdc_pkg::REG_SET_LOW:      win_low[BTN_SET] = data;
         tdc_pkg::REG_SET_HIGH:     win_high[BTN_SET] = data;
         tdc_pkg::REG_UP_LOW:       win_low[BTN_UP] = data;
         tdc_pkg::REG_UP_HIGH:      win_high[BTN_UP] = data;
         tdc_pkg::REG_DOWN_LOW:     win_low[BTN_DOWN] = data;
         tdc_pkg::REG_DOWN_HIGH:    win_high[BTN_DOWN] = data;
         tdc_pkg::REG_IDLE_TIMEOUT: idle_limit = data[7:0];
         default: ;
      endcase
   endfunction

   // fresh press: window hit while the held bit is clear
   function automatic logic press_edge(button_type b, tdc_pkg::level_type lvl);
      if (!(lvl > win_low[b] && lvl < win_high[b])) begin
         held[b] = 1'b0;
         return 1'b0;
      end
      if (held[b]) return 1'b0;
      held[b] = 1'b1;
      return 1'b1;
   endfunction

   function automatic clock_reading_type advance_clock(logic tick, tdc_pkg::level_type lvl,
                                                       logic other);
      clock_reading_type r;
      if (tick) begin
         if (cur_mode == tdc_pkg::MODE_RUN) begin
            if (cur_second == tdc_pkg::SecLast) begin
               cur_second = '0;
               if (cur_minute == tdc_pkg::MinLast) begin
                  cur_minute = '0;
                  cur_hour = (cur_hour == tdc_pkg::HourLast) ? '0 : cur_hour + 1'b1;
               end else begin
                  cur_minute = cur_minute + 1'b1;
               end
            end else begin
               cur_second = cur_second + 1'b1;
            end
         end
         if (idle_count != tdc_pkg::IdleMax) idle_count = idle_count + 1'b1;
      end
      if (!other) begin
         if (press_edge(BTN_SET, lvl)) begin
            case (cur_mode)
               tdc_pkg::MODE_RUN:   cur_mode = tdc_pkg::MODE_HOURS;
               tdc_pkg::MODE_HOURS: cur_mode = tdc_pkg::MODE_MINUTES;
               default:             cur_mode = tdc_pkg::MODE_RUN;
            endcase
            idle_count = '0;
         end
         if (cur_mode != tdc_pkg::MODE_RUN && idle_count > idle_limit) begin
            cur_mode = tdc_pkg::MODE_RUN;
            idle_count = '0;
         end
         if (press_edge(BTN_UP, lvl)) begin
            idle_count = '0;
            if (cur_mode == tdc_pkg::MODE_HOURS)
               cur_hour = (cur_hour == tdc_pkg::HourLast) ? '0 : cur_hour + 1'b1;
            else if (cur_mode == tdc_pkg::MODE_MINUTES)
               cur_minute = (cur_minute == tdc_pkg::MinLast) ? '0 : cur_minute + 1'b1;
         end
         if (press_edge(BTN_DOWN, lvl)) begin
            idle_count = '0;
            if (cur_mode == tdc_pkg::MODE_HOURS)
               cur_hour = (cur_hour == '0) ? tdc_pkg::HourLast : cur_hour - 1'b1;
            else if (cur_mode == tdc_pkg::MODE_MINUTES)
               cur_minute = (cur_minute == '0) ? tdc_pkg::MinLast : cur_minute - 1'b1;
         end
      end
      r.hour = cur_hour;
      r.minute = cur_minute;
      r.second = cur_second;
      r.state = cur_mode;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // checking: every edge, responses first, then csr writes, then requests
   // ---------------------------------------------------------------------

   task automatic flag_field(string field, int want, int got);
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
   endtask

   always @(posedge clock) begin
      clock_reading_type want;
      if (reset) begin
         reset_clock_model();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_readings.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected response, expected none, got %0d:%0d:%0d state %0d",
                        $time, rsp_hour_now, rsp_minute_now, rsp_second_now,
                        rsp_clock_state);
            end else begin
               want = expected_readings.pop_front();
               if (rsp_hour_now !== want.hour) flag_field("hour", want.hour, rsp_hour_now);
               if (rsp_minute_now !== want.minute)
                  flag_field("minute", want.minute, rsp_minute_now);
               if (rsp_second_now !== want.second)
                  flag_field("second", want.second, rsp_second_now);
               if (rsp_clock_state !== want.state)
                  flag_field("clock state", want.state, rsp_clock_state);
            end
         end
         if (csr_wr_en) apply_csr(csr_index, csr_wdata);
         if (req_valid && req_ready) begin
            want = advance_clock(req_second_tick, req_key_level, req_other_screen);
            // a pinned row is held to its typed response, the model still steps
            if (pin_valid) want = pin_reading;
            expected_readings.push_back(want);
         end
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   // mostly short gaps, a few long ones, and calm stretches with none at all
   function automatic int pick_gap(int side);
      int r;
      if (calm_left[side] == 0) begin
         calm[side] = ($urandom_range(0, 3) == 0);
         calm_left[side] = $urandom_range(8, 60);
      end
      calm_left[side]--;
      r = $urandom_range(0, 99);
      if (calm[side] || r < 50) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic chance(int pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   function automatic logic in_any_window(int lvl);
      foreach (win_low[i])
         if (lvl > int'(win_low[i]) && lvl < int'(win_high[i])) return 1'b1;
      return 1'b0;
   endfunction

   // a sample inside one button window, or anything when the window is empty
   function automatic tdc_pkg::level_type hit_level(button_type b);
      int lo;
      int hi;
      lo = win_low[b];
      hi = win_high[b];
      if (hi - lo >= 2) return tdc_pkg::level_type'($urandom_range(lo + 1, hi - 1));
      return tdc_pkg::level_type'($urandom_range(0, LevelTop));
   endfunction

   // a sample that presses nothing; zero can never sit above a lower bound
   function automatic tdc_pkg::level_type quiet_level();
      int lvl;
      repeat (8) begin
         lvl = $urandom_range(0, LevelTop);
         if (!in_any_window(lvl)) return tdc_pkg::level_type'(lvl);
      end
      return '0;
   endfunction

   function automatic int taps_to_hours(tdc_pkg::mode_type m);
      case (m)
         tdc_pkg::MODE_RUN:   return 1;
         tdc_pkg::MODE_HOURS: return 0;
         default:             return 2;
      endcase
   endfunction

   function automatic void add_row(logic tick, int lvl, logic other);
      stim_row_type row;
      row = '0;
      row.tick = tick;
      row.level = tdc_pkg::level_type'(lvl);
      row.other = other;
      directed_rows.push_back(row);
   endfunction

   function automatic void pin_row(logic tick, int lvl, logic other, int h, int m, int s,
                                   tdc_pkg::mode_type md);
      stim_row_type row;
      row.tick = tick;
      row.level = tdc_pkg::level_type'(lvl);
      row.other = other;
      row.pinned = 1'b1;
      row.reading.hour = tdc_pkg::hour_type'(h);
      row.reading.minute = tdc_pkg::min_type'(m);
      row.reading.second = tdc_pkg::sec_type'(s);
      row.reading.state = md;
      directed_rows.push_back(row);
   endfunction

   // offer one request after a random gap and hold it until accepted
   task automatic send_request(logic tick, tdc_pkg::level_type lvl, logic other,
                               logic pinned, clock_reading_type reading);
      int gap;
      gap = pick_gap(SideReq);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_second_tick <= tick;
      req_key_level <= lvl;
      req_other_screen <= other;
      pin_valid <= pinned;
      pin_reading <= reading;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_plain(logic tick, tdc_pkg::level_type lvl, logic other);
      send_request(tick, lvl, other, 1'b0, '0);
   endtask

   // press one button and let go, no tick
   task automatic tap(button_type b);
      send_plain(1'b0, hit_level(b), 1'b0);
      send_plain(1'b0, quiet_level(), 1'b0);
   endtask

   // stop offering and wait until every response is back
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_readings.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   // leaves the write enable high; the caller drops it after the last write
   task automatic csr_write(logic [tdc_pkg::CsrIndexBits-1:0] idx, csr_word_type data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic load_csrs(int set_lo, int set_hi, int up_lo, int up_hi, int dn_lo,
                            int dn_hi, int timeout_word);
      csr_write(tdc_pkg::REG_SET_LOW, csr_word_type'(set_lo));
      csr_write(tdc_pkg::REG_SET_HIGH, csr_word_type'(set_hi));
      csr_write(tdc_pkg::REG_UP_LOW, csr_word_type'(up_lo));
      csr_write(tdc_pkg::REG_UP_HIGH, csr_word_type'(up_hi));
      csr_write(tdc_pkg::REG_DOWN_LOW, csr_word_type'(dn_lo));
      csr_write(tdc_pkg::REG_DOWN_HIGH, csr_word_type'(dn_hi));
      csr_write(tdc_pkg::REG_IDLE_TIMEOUT, csr_word_type'(timeout_word));
      csr_wr_en <= 1'b0;
   endtask

   // random episodes: presses with releases, running seconds, set cycling,
   // other-screen bursts over live windows, and plain noise
   task automatic run_random(int budget);
      int sent;
      int kind;
      int n;
      button_type b;
      tdc_pkg::level_type lvl;
      sent = 0;
      while (sent < budget) begin
         kind = $urandom_range(0, 99);
         if (kind < 35) begin
            b = button_type'($urandom_range(0, 2));
            lvl = hit_level(b);
            n = $urandom_range(1, 3);
            repeat (n) send_plain(chance(25), lvl, chance(5));
            send_plain(chance(25), quiet_level(), 1'b0);
            sent += n + 1;
         end else if (kind < 65) begin
            n = $urandom_range(5, 40);
            repeat (n) send_plain(chance(85), quiet_level(), chance(10));
            sent += n;
         end else if (kind < 80) begin
            n = $urandom_range(1, 3);
            repeat (n) begin
               send_plain(chance(20), hit_level(BTN_SET), 1'b0);
               send_plain(chance(20), quiet_level(), 1'b0);
            end
            sent += 2 * n;
         end else if (kind < 90) begin
            n = $urandom_range(2, 10);
            repeat (n) send_plain(chance(50), hit_level(button_type'($urandom_range(0, 2))),
                                  1'b1);
            sent += n;
         end else begin
            n = $urandom_range(1, 10);
            repeat (n) send_plain(chance(50),
                                  tdc_pkg::level_type'($urandom_range(0, LevelTop)),
                                  chance(50));
            sent += n;
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // receiver: ready drops for random gaps
   // ---------------------------------------------------------------------

   initial begin
      int gap;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         gap = pick_gap(SideRsp);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #20_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------

   initial begin
      int h0;
      int m0;
      int s0;
      int rlo [3];
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_second_tick = 1'b0;
      req_key_level = '0;
      req_other_screen = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      pin_valid = 1'b0;
      pin_reading = '0;
      mismatches = 0;

      // directed rows against the reset windows (set 340..450, up 210..280,
      // down 130..200, timeout 5); bounds themselves are outside a window
      pin_row(1'b0, 0, 1'b0, 0, 0, 0, tdc_pkg::MODE_RUN);          // reset state
      pin_row(1'b1, LevelTop, 1'b0, 0, 0, 1, tdc_pkg::MODE_RUN);   // top sample, one tick
      pin_row(1'b1, 0, 1'b1, 0, 0, 2, tdc_pkg::MODE_RUN);          // other screen ticks
      pin_row(1'b0, 400, 1'b0, 0, 0, 2, tdc_pkg::MODE_HOURS);      // set press
      pin_row(1'b0, 400, 1'b0, 0, 0, 2, tdc_pkg::MODE_HOURS);      // set held, no repeat
      add_row(1'b0, 0, 1'b0);                                      // release
      pin_row(1'b0, 250, 1'b0, 1, 0, 2, tdc_pkg::MODE_HOURS);      // up
      add_row(1'b0, 160, 1'b0);                                    // straight to down
      add_row(1'b0, 0, 1'b0);
      pin_row(1'b0, 160, 1'b0, 23, 0, 2, tdc_pkg::MODE_HOURS);     // down wraps 0 to 23
      pin_row(1'b0, 250, 1'b0, 0, 0, 2, tdc_pkg::MODE_HOURS);      // up wraps 23 to 0
      pin_row(1'b0, 341, 1'b0, 0, 0, 2, tdc_pkg::MODE_MINUTES);    // just inside set window
      add_row(1'b0, 340, 1'b0);                                    // on the lower bound
      pin_row(1'b0, 199, 1'b0, 0, 59, 2, tdc_pkg::MODE_MINUTES);   // minutes wrap down
      add_row(1'b0, 200, 1'b0);                                    // on the upper bound
      pin_row(1'b0, 211, 1'b0, 0, 0, 2, tdc_pkg::MODE_MINUTES);    // minutes wrap up
      add_row(1'b1, 400, 1'b1);                                    // held bits frozen
      add_row(1'b1, 250, 1'b0);                                    // up still held
      add_row(1'b1, 0, 1'b0);
      add_row(1'b1, 0, 1'b0);
      add_row(1'b1, 0, 1'b0);
      pin_row(1'b1, 0, 1'b0, 0, 0, 2, tdc_pkg::MODE_RUN);          // idle timeout
      add_row(1'b1, 0, 1'b0);
      pin_row(1'b0, 250, 1'b0, 0, 0, 3, tdc_pkg::MODE_RUN);        // up while running
      pin_row(1'b1, 450, 1'b0, 0, 0, 4, tdc_pkg::MODE_RUN);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i].tick, directed_rows[i].level, directed_rows[i].other,
                      directed_rows[i].pinned, directed_rows[i].reading);

      // reset windows rewritten, timeout at its floor
      settle();
      load_csrs(340, 450, 210, 280, 130, 200, 0);
      run_random(130);

      // overlapping windows, down spanning the whole range
      settle();
      load_csrs(100, 600, 300, 900, 0, LevelTop, 3);
      run_random(130);

      // up and down windows empty; timeout word with spare upper bits;
      // a write past the register list must change nothing
      settle();
      load_csrs(340, 450, 600, 601, LevelTop, 0, 10'h305);
      csr_write(RegUnused, '0);
      csr_wr_en <= 1'b0;
      run_random(130);

      // random narrow windows
      settle();
      foreach (rlo[i]) rlo[i] = $urandom_range(0, 900);
      load_csrs(rlo[0], rlo[0] + $urandom_range(0, 120), rlo[1], rlo[1] + $urandom_range(0, 120),
                rlo[2], rlo[2] + $urandom_range(0, 120), $urandom_range(0, 12));
      run_random(130);

      // walk the time to 23:59 and let it roll over to midnight
      settle();
      load_csrs(340, 450, 210, 280, 130, 200, 200);
      // let go of every button first so the first tap counts
      send_plain(1'b0, quiet_level(), 1'b0);
      settle();
      h0 = cur_hour;
      m0 = cur_minute;
      s0 = cur_second;
      repeat (taps_to_hours(cur_mode)) tap(BTN_SET);
      if (h0 >= 12) repeat (int'(tdc_pkg::HourLast) - h0) tap(BTN_UP);
      else repeat (h0 + 1) tap(BTN_DOWN);
      tap(BTN_SET);
      if (m0 >= 30) repeat (int'(tdc_pkg::MinLast) - m0) tap(BTN_UP);
      else repeat (m0 + 1) tap(BTN_DOWN);
      tap(BTN_SET);
      repeat (62 - s0) send_plain(1'b1, quiet_level(), chance(10));
      run_random(100);

      // idle counter saturates under the other screen; a timeout of 255
      // can never be exceeded, 254 is left on the next plain request
      settle();
      load_csrs(340, 450, 210, 280, 130, 200, int'(tdc_pkg::IdleMax));
      send_plain(1'b0, quiet_level(), 1'b0);
      settle();
      repeat (taps_to_hours(cur_mode)) tap(BTN_SET);
      repeat (258) send_plain(1'b1, tdc_pkg::level_type'($urandom_range(0, LevelTop)), 1'b1);
      repeat (3) send_plain(1'b0, quiet_level(), 1'b0);
      settle();
      csr_write(tdc_pkg::REG_IDLE_TIMEOUT, csr_word_type'(tdc_pkg::IdleMax - 1'b1));
      csr_wr_en <= 1'b0;
      send_plain(1'b0, quiet_level(), 1'b0);
      run_random(60);

      settle();
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/tdc_pkg.sv
sv/tdc_front.sv
sv/tdc_fifo.sv
sv/tdc_back.sv
sv/time_of_day_clock_with_button_setting_top.sv
bench/tb.sv
